>>> rtl/rcrp_pkg.sv
// Shared types, codes and register-map helpers for the radio config reply parser.
`timescale 1ns / 1ps

package rcrp_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hC1;
  localparam logic [7:0] PID_MAP0  = 8'h80;
  localparam logic [7:0] PID_MAP1  = 8'hFF;
  localparam int         NREGS     = 7;
  localparam int         SLOT_W    = $clog2(NREGS + 1);
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(NREGS);

  // Cache slot order
  localparam int SLOT_ADDR_H = 0;
  localparam int SLOT_ADDR_L = 1;
  localparam int SLOT_NETID  = 2;
  localparam int SLOT_SET0   = 3;
  localparam int SLOT_SET1   = 4;
  localparam int SLOT_SET2   = 5;
  localparam int SLOT_SET3   = 6;

  localparam logic OP_RX  = 1'b0;
  localparam logic OP_ARM = 1'b1;

  localparam logic MAP_NETID   = 1'b0;
  localparam logic MAP_NONETID = 1'b1;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_ADDR,
    PH_LEN,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  addr_high;
    logic [7:0]  addr_low;
    logic [7:0]  network_id;
    logic [7:0]  setting0;
    logic [7:0]  setting1;
    logic [7:0]  setting2;
    logic [7:0]  setting3;
    logic [15:0] node_id;
    logic [7:0]  channel;
  } out_t;

  // Map a register address onto a cache slot, NO_SLOT when unmapped.
  function automatic logic [SLOT_W-1:0] slot_of(input logic map, input logic [7:0] a);
    logic [SLOT_W-1:0] s;
    s = NO_SLOT;
    if (map == MAP_NETID) begin
      if (a < 8'(NREGS)) s = a[SLOT_W-1:0];
    end else begin
      if (a < 8'd2)      s = a[SLOT_W-1:0];
      else if (a < 8'd6) s = a[SLOT_W-1:0] + SLOT_W'(1);
    end
    return s;
  endfunction

endpackage

>>> rtl/rcrp_parser.sv
// Reply parse state machine and register cache; one registered item per cycle.
`timescale 1ns / 1ps

module rcrp_parser
  import rcrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic item_vld,
  input  in_t  item,
  input  logic map_sel,
  output logic res_vld,
  output out_t res
);

  logic       armed_r, armed_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] start_r, start_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic       discard_r, discard_nxt;
  logic [7:0] copies_r   [NREGS];
  logic [7:0] copies_nxt [NREGS];

  logic [7:0]        b;
  logic [7:0]        idx_inc;
  logic [7:0]        pid;
  logic [SLOT_W-1:0] slot;
  logic              new_discard;

  assign b           = item.rx_byte;
  assign idx_inc     = idx_r + 8'd1;
  assign pid         = (map_sel == MAP_NONETID) ? PID_MAP1 : PID_MAP0;
  assign slot        = slot_of(map_sel, start_r + idx_r);
  assign new_discard = (start_r == pid);

  always_comb begin
    armed_nxt   = armed_r;
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    discard_nxt = discard_r;
    copies_nxt  = copies_r;
    res_vld     = 1'b0;
    if (item_vld) begin
      if (item.op == OP_ARM) begin
        armed_nxt = 1'b1;
        phase_nxt = PH_SEEK;
      end else if (armed_r) begin
        case (phase_r)
          PH_SEEK: begin
            if (b == HDR_BYTE) phase_nxt = PH_ADDR;
          end
          PH_ADDR: begin
            start_nxt = b;
            phase_nxt = PH_LEN;
          end
          PH_LEN: begin
            count_nxt   = b;
            idx_nxt     = 8'd0;
            discard_nxt = new_discard;
            if (b == 8'd0) begin
              phase_nxt = PH_SEEK;
              if (!new_discard) begin
                armed_nxt = 1'b0;
                res_vld   = 1'b1;
              end
            end else begin
              phase_nxt = PH_DATA;
            end
          end
          default: begin
            if (!discard_r) begin
              for (int i = 0; i < NREGS; i++) begin
                if (slot == SLOT_W'(i)) copies_nxt[i] = b;
              end
            end
            idx_nxt = idx_inc;
            // reply done: drop a product-info reply, else disarm and report
            if (idx_inc == count_r) begin
              phase_nxt = PH_SEEK;
              if (!discard_r) begin
                armed_nxt = 1'b0;
                res_vld   = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    res.addr_high  = copies_nxt[SLOT_ADDR_H];
    res.addr_low   = copies_nxt[SLOT_ADDR_L];
    res.network_id = copies_nxt[SLOT_NETID];
    res.setting0   = copies_nxt[SLOT_SET0];
    res.setting1   = copies_nxt[SLOT_SET1];
    res.setting2   = copies_nxt[SLOT_SET2];
    res.setting3   = copies_nxt[SLOT_SET3];
    res.node_id    = {copies_nxt[SLOT_ADDR_H], copies_nxt[SLOT_ADDR_L]};
    res.channel    = copies_nxt[SLOT_SET2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      phase_r   <= PH_SEEK;
      start_r   <= 8'd0;
      count_r   <= 8'd0;
      idx_r     <= 8'd0;
      discard_r <= 1'b0;
      for (int i = 0; i < NREGS; i++) copies_r[i] <= 8'd0;
    end else begin
      armed_r   <= armed_nxt;
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      count_r   <= count_nxt;
      idx_r     <= idx_nxt;
      discard_r <= discard_nxt;
      copies_r  <= copies_nxt;
    end
  end

endmodule

>>> rtl/rcrp_out_buf.sv
// Two-entry result buffer that decouples the parser from output stalls.
`timescale 1ns / 1ps

module rcrp_out_buf
  import rcrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  out_t       push_data,
  input  logic       pop,
  output logic       not_empty,
  output logic [1:0] count,
  output out_t       head
);

  out_t       mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign count     = cnt_r;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/radio_config_reply_parser.sv
// Top level of the radio config reply parser: input register, parser, result buffer.
`timescale 1ns / 1ps

// Takes one item per clock (a received byte or a command-sent mark) and gives
// one result when an armed reply completes. Each item is registered on
// transfer, decoded by the parser in the next cycle and lands in a two-entry
// result buffer, so out_valid rises once the result for the last byte of a reply
// is in the buffer. Input stall rises only while the buffer count plus the item
// in flight, less any result popped now, would reach two entries; with the output
// free-flowing, one item is taken every cycle. The map select register
// is always ready and must be written only while the block is idle.
module radio_config_reply_parser
  import rcrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic       in_vld_r, in_vld_nxt;
  in_t        in_item_r;
  logic       map_sel_r;
  logic       res_vld;
  out_t       res;
  logic       pop;
  logic [1:0] buf_cnt;
  logic [2:0] load;

  assign cfg_ready = 1'b1;
  assign pop       = out_valid && !out_stall;
  // hold input while the buffer, counting the item now in flight, could not take one more
  assign load      = {1'b0, buf_cnt} + {2'b00, in_vld_r} - {2'b00, pop};
  assign in_stall  = (load > 3'd1);
  assign in_vld_nxt = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      map_sel_r <= MAP_NETID;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (cfg_valid && cfg_ready) map_sel_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_nxt) in_item_r <= in_data;
  end

  rcrp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_vld_r),
    .item     (in_item_r),
    .map_sel  (map_sel_r),
    .res_vld  (res_vld),
    .res      (res)
  );

  rcrp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (pop),
    .not_empty (out_valid),
    .count     (buf_cnt),
    .head      (out_data)
  );

endmodule

>>> rtl/rcrp_checker.sv
// Port-level checks for the radio config reply parser, bound to the top level.
`timescale 1ns / 1ps

module rcrp_checker
  import rcrp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a result waiting on a stall stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_node_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.node_id == {out_data.addr_high, out_data.addr_low})
    else $error("node_id does not match address bytes");

  a_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.channel == out_data.setting2)
    else $error("channel does not match setting2");

  // an empty result buffer never holds off input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

endmodule

bind radio_config_reply_parser rcrp_checker u_rcrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/sv/tb_radio_config_reply_parser.sv
// Testbench for radio_config_reply_parser: directed and random reply streams checked
// against a cycle-free model of the parser.
`timescale 1ns / 1ps

module tb_radio_config_reply_parser;
  import rcrp_pkg::*;

  localparam int IDLE_HOLD   = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef logic [7:0] byte_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  radio_config_reply_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser model state
  logic       map_sel = MAP_NETID;
  logic       listening = 1'b0;
  phase_t     parse_phase = PH_SEEK;
  logic [7:0] reply_base = '0;
  logic [7:0] reply_len = '0;
  logic [7:0] reply_pos = '0;
  logic       dropping = 1'b0;
  logic [7:0] reg_cache [NREGS];

  out_t pending_replies[$];
  out_t due_reply;
  int   mismatches = 0;
  int   replies_seen = 0;
  int   sent_count = 0;
  int   cycles = 0;
  int   rx_hold = 0;
  bit   quiet = 1'b0;

  initial foreach (reg_cache[i]) reg_cache[i] = '0;

  function automatic int pick_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Cache slot for a register address under the current map, -1 when unmapped.
  function automatic int reg_slot(input logic [7:0] a);
    if (map_sel == MAP_NETID) return (a < NREGS) ? int'(a) : -1;
    case (a)
      8'd0, 8'd1:             return int'(a);
      8'd2, 8'd3, 8'd4, 8'd5: return int'(a) + 1;
      default:                return -1;
    endcase
  endfunction

  function automatic void close_reply();
    out_t r;
    parse_phase = PH_SEEK;
    if (dropping) return;
    listening     = 1'b0;
    r.addr_high  = reg_cache[SLOT_ADDR_H];
    r.addr_low   = reg_cache[SLOT_ADDR_L];
    r.network_id = reg_cache[SLOT_NETID];
    r.setting0   = reg_cache[SLOT_SET0];
    r.setting1   = reg_cache[SLOT_SET1];
    r.setting2   = reg_cache[SLOT_SET2];
    r.setting3   = reg_cache[SLOT_SET3];
    r.node_id    = {reg_cache[SLOT_ADDR_H], reg_cache[SLOT_ADDR_L]};
    r.channel    = reg_cache[SLOT_SET2];
    pending_replies.push_back(r);
  endfunction

  function automatic void parse_byte(input in_t item);
    logic [7:0] b;
    int s;
    b = item.rx_byte;
    if (item.op == OP_ARM) begin
      listening   = 1'b1;
      parse_phase = PH_SEEK;
      return;
    end
    if (!listening) return;
    case (parse_phase)
      PH_SEEK: begin
        if (b == HDR_BYTE) parse_phase = PH_ADDR;
      end
      PH_ADDR: begin
        reply_base  = b;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        reply_len = b;
        reply_pos = '0;
        dropping  = (reply_base == ((map_sel == MAP_NONETID) ? PID_MAP1 : PID_MAP0));
        if (reply_len == 8'd0) close_reply();
        else parse_phase = PH_DATA;
      end
      default: begin
        if (!dropping) begin
          s = reg_slot(reply_base + reply_pos);
          if (s >= 0) reg_cache[s] = b;
        end
        reply_pos = reply_pos + 8'd1;
        if (reply_pos == reply_len) close_reply();
      end
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [7:0] b);
    in_t item;
    int gap;
    item.op      = op;
    item.rx_byte = b;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    sent_count++;
    parse_byte(item);
  endtask

  task automatic send_bytes(input byte_q_t seq);
    foreach (seq[i]) send_item(OP_RX, seq[i]);
  endtask

  // Hold the sender until every reply is out and the pipeline has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (IDLE_HOLD) @(posedge clk);
  endtask

  task automatic set_map(input logic m);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    map_sel = m;
  endtask

  task automatic test_full_reply();
    send_bytes('{HDR_BYTE, 8'h00});  // not armed yet: ignored
    send_item(OP_ARM, 8'($urandom));
    send_bytes('{8'h7E, HDR_BYTE, 8'h00, 8'd7,
                 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F});
  endtask

  task automatic test_drop_and_wrap();
    send_item(OP_ARM, 8'($urandom));
    // product-info reply is swallowed, then a reply whose address wraps past 0xFF
    send_bytes('{HDR_BYTE, PID_MAP0, 8'd1, 8'h33,
                 HDR_BYTE, 8'hFE, 8'd3, 8'h11, 8'h22, 8'h44});
  endtask

  task automatic test_abort_and_zero_len();
    send_item(OP_ARM, 8'($urandom));
    send_bytes('{HDR_BYTE, 8'h02});
    send_item(OP_ARM, 8'($urandom));
    send_bytes('{HDR_BYTE, 8'h03, 8'h00});
  endtask

  task automatic test_no_netid_map();
    set_map(MAP_NONETID);
    send_item(OP_ARM, 8'($urandom));
    send_bytes('{HDR_BYTE, PID_MAP1, 8'h00,
                 HDR_BYTE, 8'h00, 8'd7,
                 8'hC3, 8'h3C, 8'h96, 8'h69, 8'hF0, 8'h0F, 8'hEE});
    send_item(OP_ARM, 8'($urandom));
    send_bytes('{HDR_BYTE, PID_MAP0, 8'd2, 8'h12, 8'h34});
  endtask

  task automatic test_random_replies(input logic m, input int budget, input bit calm);
    int first;
    int kind;
    int len;
    int cut;
    logic [7:0] b;
    logic [7:0] base;
    set_map(m);
    quiet = calm;
    first = sent_count;
    while (sent_count - first < budget) begin
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
        repeat ($urandom_range(1, 4))
          send_item($urandom_range(0, 1) ? OP_ARM : OP_RX, 8'($urandom));
      end else begin
        if (kind != 1) send_item(OP_ARM, 8'($urandom));
        repeat ($urandom_range(0, 3)) begin
          b = 8'($urandom);
          if (b == HDR_BYTE) b = ~b;
          send_item(OP_RX, b);
        end
        send_item(OP_RX, HDR_BYTE);
        case ($urandom_range(0, 7))
          0:       base = (map_sel == MAP_NONETID) ? PID_MAP1 : PID_MAP0;
          1:       base = 8'($urandom);
          2:       base = 8'hF8 + 8'($urandom_range(0, 7));
          default: base = 8'($urandom_range(0, 7));
        endcase
        send_item(OP_RX, base);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        send_item(OP_RX, 8'(len));
        // a short reply leaves the parser mid-stream for the next arm to abandon
        cut = (kind == 2) ? $urandom_range(0, len) : len;
        repeat (cut) send_item(OP_RX, 8'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // Receiver: stall for a random count while a reply is presented, check each transfer.
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("reply %0d: %s expected %h, got %h", replies_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("reply %0d: none expected, got %p", replies_seen, out_data);
        end else begin
          due_reply = pending_replies.pop_front();
          check_field("addr_high", due_reply.addr_high, out_data.addr_high);
          check_field("addr_low", due_reply.addr_low, out_data.addr_low);
          check_field("network_id", due_reply.network_id, out_data.network_id);
          check_field("setting0", due_reply.setting0, out_data.setting0);
          check_field("setting1", due_reply.setting1, out_data.setting1);
          check_field("setting2", due_reply.setting2, out_data.setting2);
          check_field("setting3", due_reply.setting3, out_data.setting3);
          check_field("node_id", due_reply.node_id, out_data.node_id);
          check_field("channel", due_reply.channel, out_data.channel);
        end
        replies_seen++;
        rx_hold = pick_wait();
      end else if (out_valid && rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold > 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** radio_config_reply_parser: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_full_reply();
    test_drop_and_wrap();
    test_abort_and_zero_len();
    test_no_netid_map();
    test_random_replies(MAP_NETID, 250, 1'b0);
    test_random_replies(MAP_NONETID, 250, 1'b0);
    test_random_replies(MAP_NETID, 200, 1'b1);
    test_random_replies(MAP_NONETID, 200, 1'b0);
    wait_idle();
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("** radio_config_reply_parser: PASSED **");
    end else begin
      $display("** radio_config_reply_parser: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rcrp_pkg.sv
rtl/rcrp_parser.sv
rtl/rcrp_out_buf.sv
rtl/radio_config_reply_parser.sv
rtl/rcrp_checker.sv
tb/sv/tb_radio_config_reply_parser.sv
